[sv/gfp_pkg.sv]
// Package: shared types, register indexes and constants of the Gaussian force perturbation.
package gfp_pkg;

  // Fixed point format of coordinates, times and the factor
  localparam int FRAC_BITS = 16;
  localparam logic [32:0] ONE_FX = 33'(1) << FRAC_BITS;

  // Pipeline depths
  localparam int FRONT_STAGES = 3;
  localparam int DIV_STEPS    = 33;
  localparam int NTERMS       = 12;
  localparam int NSQUARE      = 3;
  localparam int EXP_STAGES   = 2 + 3 * NTERMS + 1 + NSQUARE;
  localparam int LATENCY      = 1 + FRONT_STAGES + DIV_STEPS + EXP_STAGES + 2;

  // Register indexes
  localparam logic [3:0] CFG_ENABLE       = 4'd0;
  localparam logic [3:0] CFG_CENTER_X     = 4'd1;
  localparam logic [3:0] CFG_CENTER_Y     = 4'd2;
  localparam logic [3:0] CFG_CENTER_Z     = 4'd3;
  localparam logic [3:0] CFG_RADIUS       = 4'd4;
  localparam logic [3:0] CFG_SCALE_FACTOR = 4'd5;
  localparam logic [3:0] CFG_START_TIME   = 4'd6;
  localparam logic [3:0] CFG_DURATION     = 4'd7;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] time_now;
  } gfp_cmd_t;

  typedef struct packed {
    logic signed [31:0] variation;
    logic               in_region;
  } gfp_res_t;

  typedef struct packed {
    logic               enable;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic signed [31:0] scale_factor;
    logic signed [31:0] start_time;
    logic [30:0]        duration;
  } gfp_cfg_t;

  // Valid and region flags that travel with each request
  typedef struct packed {
    logic vld;
    logic inr;
  } gfp_ctl_t;

  // floor(2^32 / k) for the series divisors
  function automatic logic [31:0] gfp_recip(input int k);
    logic [31:0] r;
    case (k)
      2:       r = 32'd2147483648;
      3:       r = 32'd1431655765;
      4:       r = 32'd1073741824;
      5:       r = 32'd858993459;
      6:       r = 32'd715827882;
      7:       r = 32'd613566756;
      8:       r = 32'd536870912;
      9:       r = 32'd477218588;
      10:      r = 32'd429496729;
      11:      r = 32'd390451572;
      12:      r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/gaussian_force_perturbation_top.sv]
// Top level: registers, request pipeline and final scaling of the Gaussian force perturbation.
//
//  port group   direction  handshake               payload
//  request      in         start_i, busy_o         cmd_i (gfp_cmd_t)
//  result       out        done_o (one-cycle)      result_o (gfp_res_t)
//  register     in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request enters per cycle; busy_o stays low, so start_i is never refused.
// Each result is accepted on done_o once its request has passed the input register,
// front end, 33-step divider, 12-term exponential series pipeline and scaling registers.
// The result side cannot stall; the pipeline advances every cycle.
// Reset clears the registers (scale factor to 1.0) and all valid flags.
module gaussian_force_perturbation_top import gfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  gfp_cmd_t    cmd_i,
  output logic        done_o,
  output gfp_res_t    result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  gfp_cfg_t    cfg_q;
  logic [61:0] r2_q;
  logic [32:0] m_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold registers; decode writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{scale_factor: $signed(ONE_FX[31:0]), default: '0};
      r2_q  <= '0;
      m_q   <= '0;
    end else begin
      r2_q <= 62'(cfg_q.radius) * 62'(cfg_q.radius);
      m_q  <= 33'(cfg_q.duration) * 33'd3;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ENABLE:       cfg_q.enable       <= cfg_data_i[0];
          CFG_CENTER_X:     cfg_q.center_x     <= cfg_data_i;
          CFG_CENTER_Y:     cfg_q.center_y     <= cfg_data_i;
          CFG_CENTER_Z:     cfg_q.center_z     <= cfg_data_i;
          CFG_RADIUS:       cfg_q.radius       <= cfg_data_i[30:0];
          CFG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_data_i;
          CFG_START_TIME:   cfg_q.start_time   <= cfg_data_i;
          CFG_DURATION:     cfg_q.duration     <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // Capture the request
  logic     in_vld_q;
  gfp_cmd_t cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_i;
  end

  gfp_ctl_t    f_ctl, d_ctl, e_ctl;
  logic [63:0] f_dd;
  logic [31:0] f_n, d_qb;
  logic [32:0] d_a;
  logic [30:0] e_g;

  gfp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .r2_i   (r2_q),
    .vld_i  (in_vld_q),
    .cmd_i  (cmd_q),
    .ctl_o  (f_ctl),
    .dd_o   (f_dd),
    .n_o    (f_n)
  );

  gfp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .r2_i   (r2_q),
    .m_i    (m_q),
    .ctl_i  (f_ctl),
    .dd_i   (f_dd),
    .n_i    (f_n),
    .ctl_o  (d_ctl),
    .a_o    (d_a),
    .qb_o   (d_qb)
  );

  gfp_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (d_ctl),
    .a_i    (d_a),
    .qb_i   (d_qb),
    .ctl_o  (e_ctl),
    .g_o    (e_g)
  );

  // Scale by factor minus one
  logic signed [32:0] v_s;
  logic [32:0]        v_mag;
  gfp_ctl_t           p_ctl_q;
  logic               p_neg_q;
  logic [63:0]        p_prod_q;
  logic [64:0]        p_rnd;
  logic [34:0]        mag;
  logic signed [31:0] res_v;

  assign v_s   = 33'(cfg_q.scale_factor) - $signed(ONE_FX);
  assign v_mag = v_s[32] ? 33'(-v_s) : v_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctl_q <= '0;
    end else begin
      p_ctl_q <= e_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    p_neg_q  <= v_s[32];
    p_prod_q <= 64'(v_mag) * 64'(e_g);
  end

  // Round half away from zero and saturate
  always_comb begin
    p_rnd = 65'(p_prod_q) + (65'(1) << 29);
    mag   = p_rnd[64:30];
    if (p_neg_q) begin
      res_v = (mag > 35'h080000000) ? 32'sh80000000 : 32'(-$signed({1'b0, mag}));
    end else begin
      res_v = (mag > 35'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
    end
  end

  gfp_res_t res_q;
  logic     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p_ctl_q.vld;
    end
  end

  // Drop the value outside the region
  always_ff @(posedge clk_i) begin
    res_q.in_region <= p_ctl_q.inr;
    res_q.variation <= p_ctl_q.inr ? res_v : '0;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[sv/gfp_front.sv]
// Front end: time window, box test, squared distance and time offset.
module gfp_front import gfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gfp_cfg_t    cfg_i,
  input  logic [61:0] r2_i,
  input  logic        vld_i,
  input  gfp_cmd_t    cmd_i,
  output gfp_ctl_t    ctl_o,
  output logic [63:0] dd_o,
  output logic [31:0] n_o
);

  logic signed [32:0] t_s, st_s, hi_s, w_s;
  logic signed [32:0] ddx, ddy, ddz;
  logic [31:0]        dx, dy, dz, two_r;
  logic [32:0]        w3, dur33, n33;
  logic               win_ok, box_ok;

  // Window and box tests
  always_comb begin
    t_s    = 33'(cmd_i.time_now);
    st_s   = 33'(cfg_i.start_time);
    hi_s   = st_s + $signed({2'b00, cfg_i.duration});
    win_ok = cfg_i.enable && (cfg_i.radius != '0) && (cfg_i.duration != '0) &&
             (t_s >= st_s) && (t_s <= hi_s);
    ddx    = 33'(cmd_i.point_x) - 33'(cfg_i.center_x);
    ddy    = 33'(cmd_i.point_y) - 33'(cfg_i.center_y);
    ddz    = 33'(cmd_i.point_z) - 33'(cfg_i.center_z);
    dx     = ddx[32] ? 32'(-ddx) : ddx[31:0];
    dy     = ddy[32] ? 32'(-ddy) : ddy[31:0];
    dz     = ddz[32] ? 32'(-ddz) : ddz[31:0];
    two_r  = {cfg_i.radius, 1'b0};
    box_ok = (dx <= two_r) && (dy <= two_r) && (dz <= two_r);
    w_s    = t_s - st_s;
    w3     = {w_s[31:0], 1'b0} + w_s;
    dur33  = {2'b00, cfg_i.duration};
    n33    = (w3 >= dur33) ? (w3 - dur33) : (dur33 - w3);
  end

  gfp_ctl_t    ca_q, cb_q, cc_q;
  logic [31:0] dx_q, dy_q, dz_q, na_q, nb_q, nc_q;
  logic [63:0] sx_q, sy_q, sz_q, dd_q;
  logic [65:0] dd_sum;

  assign dd_sum = 66'(sx_q) + 66'(sy_q) + 66'(sz_q);

  // Advance flags; the distance limit is 4*R^2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q <= '0;
      cb_q <= '0;
      cc_q <= '0;
    end else begin
      ca_q <= '{vld: vld_i, inr: win_ok && box_ok};
      cb_q <= ca_q;
      cc_q <= '{vld: cb_q.vld, inr: cb_q.inr && (dd_sum <= {r2_i, 2'b00})};
    end
  end

  // Advance data: offsets, squares, sum
  always_ff @(posedge clk_i) begin
    dx_q <= dx;
    dy_q <= dy;
    dz_q <= dz;
    na_q <= n33[31:0];
    sx_q <= 64'(dx_q) * 64'(dx_q);
    sy_q <= 64'(dy_q) * 64'(dy_q);
    sz_q <= 64'(dz_q) * 64'(dz_q);
    nb_q <= na_q;
    dd_q <= dd_sum[63:0];
    nc_q <= nb_q;
  end

  assign ctl_o = cc_q;
  assign dd_o  = dd_q;
  assign n_o   = nc_q;

endmodule

[sv/gfp_div.sv]
// Pipelined long division: space argument a = dd*2^30/R^2 and time quotient n*2^32/(3D).
module gfp_div import gfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [61:0] r2_i,
  input  logic [32:0] m_i,
  input  gfp_ctl_t    ctl_i,
  input  logic [63:0] dd_i,
  input  logic [31:0] n_i,
  output gfp_ctl_t    ctl_o,
  output logic [32:0] a_o,
  output logic [31:0] qb_o
);

  gfp_ctl_t    ctl [DIV_STEPS+1];
  logic [63:0] ra  [DIV_STEPS+1];
  logic [32:0] qa  [DIV_STEPS+1];
  logic [33:0] rb  [DIV_STEPS+1];
  logic [31:0] qb  [DIV_STEPS+1];

  assign ctl[0] = ctl_i;
  assign ra[0]  = dd_i;
  assign qa[0]  = '0;
  assign rb[0]  = {2'b00, n_i};
  assign qb[0]  = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [63:0] ra_in, div_a;
    logic [33:0] rb_in;
    logic        bit_a, bit_b;

    // Integer part first with a scaled divisor, then one fraction bit a step
    if (i < 3) begin : g_int
      assign ra_in = ra[i];
      assign div_a = {2'b00, r2_i} << (2 - i);
    end else begin : g_frac
      assign ra_in = {ra[i][62:0], 1'b0};
      assign div_a = {2'b00, r2_i};
    end
    assign bit_a = ra_in >= div_a;
    assign rb_in = {rb[i][32:0], 1'b0};
    assign bit_b = (i < 32) && (rb_in >= {1'b0, m_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl[i+1] <= '0;
      end else begin
        ctl[i+1] <= ctl[i];
      end
    end

    always_ff @(posedge clk_i) begin
      ra[i+1] <= bit_a ? (ra_in - div_a) : ra_in;
      qa[i+1] <= {qa[i][31:0], bit_a};
      if (i < 32) begin
        rb[i+1] <= bit_b ? (rb_in - {1'b0, m_i}) : rb_in;
        qb[i+1] <= {qb[i][30:0], bit_b};
      end else begin
        rb[i+1] <= rb[i];
        qb[i+1] <= qb[i];
      end
    end
  end

  assign ctl_o = ctl[DIV_STEPS];
  assign a_o   = qa[DIV_STEPS];
  assign qb_o  = qb[DIV_STEPS];

endmodule

[sv/gfp_exp.sv]
// Pipelined exp(-e) in Q30: Taylor series of exp(-e/8), then three squarings.
module gfp_exp import gfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gfp_ctl_t    ctl_i,
  input  logic [32:0] a_i,
  input  logic [31:0] qb_i,
  output gfp_ctl_t    ctl_o,
  output logic [30:0] g_o
);

  localparam logic [30:0] Q30_ONE = 31'(1) << 30;

  gfp_ctl_t    c0_q, c1_q;
  logic [32:0] a0_q;
  logic [31:0] b0_q;
  logic [63:0] qsq;

  assign qsq = 64'(qb_i) * 64'(qb_i);

  // Series state after each term; index 0 holds the start values
  gfp_ctl_t           cc [NTERMS+1];
  logic [33:0]        ec [NTERMS+1];
  logic [30:0]        tc [NTERMS+1];
  logic signed [33:0] sc [NTERMS+1];

  // Square the time quotient, then form e = a + b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
      c1_q <= '0;
    end else begin
      c0_q <= ctl_i;
      c1_q <= c0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q  <= a_i;
    b0_q  <= qsq[63:32];
    ec[0] <= {1'b0, a0_q} + {2'b00, b0_q};
  end

  assign cc[0] = c1_q;
  assign tc[0] = Q30_ONE;
  assign sc[0] = 34'(Q30_ONE);

  for (genvar j = 0; j < NTERMS; j++) begin : g_term
    localparam int          K    = j + 1;
    localparam logic [31:0] RCP  = gfp_recip(K);
    localparam logic [34:0] KV   = 35'(K);

    gfp_ctl_t           ca_q, cb_q;
    logic [33:0]        ea_q, eb_q;
    logic signed [33:0] sa_q, sb_q;
    logic [30:0]        pa_q, pb_q, q0_q, q0, term;
    logic [64:0]        tp;
    logic [34:0]        rem;

    // Multiply the previous term by e/8
    assign tp = 65'(tc[j]) * 65'(ec[j]);
    // Divide by k through its reciprocal; low by one at most
    if (K == 1) begin : g_one
      assign q0 = pa_q;
    end else begin : g_rcp
      logic [62:0] qm;
      assign qm = 63'(pa_q) * 63'(RCP);
      assign q0 = qm[62:32];
    end
    // Correct the quotient
    assign rem  = 35'(pb_q) - 35'(q0_q) * KV;
    assign term = (rem >= KV) ? (q0_q + 31'd1) : q0_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ca_q    <= '0;
        cb_q    <= '0;
        cc[j+1] <= '0;
      end else begin
        ca_q    <= cc[j];
        cb_q    <= ca_q;
        cc[j+1] <= cb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      pa_q    <= tp[63:33];
      ea_q    <= ec[j];
      sa_q    <= sc[j];
      pb_q    <= pa_q;
      q0_q    <= q0;
      eb_q    <= ea_q;
      sb_q    <= sa_q;
      tc[j+1] <= term;
      ec[j+1] <= eb_q;
      sc[j+1] <= (K % 2 == 1) ? (sb_q - $signed(34'(term))) : (sb_q + $signed(34'(term)));
    end
  end

  // Clamp the series to [0, 1.0]
  gfp_ctl_t    gc [NSQUARE+1];
  logic [30:0] gv [NSQUARE+1];
  logic signed [33:0] sfin;

  assign sfin = sc[NTERMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc[0] <= '0;
    end else begin
      gc[0] <= cc[NTERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sfin < 0) begin
      gv[0] <= '0;
    end else if (sfin > $signed(34'(Q30_ONE))) begin
      gv[0] <= Q30_ONE;
    end else begin
      gv[0] <= sfin[30:0];
    end
  end

  // Square three times with rounding
  for (genvar s = 0; s < NSQUARE; s++) begin : g_sq
    logic [61:0] gsq;
    assign gsq = 62'(gv[s]) * 62'(gv[s]) + (62'(1) << 29);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        gc[s+1] <= '0;
      end else begin
        gc[s+1] <= gc[s];
      end
    end

    always_ff @(posedge clk_i) begin
      gv[s+1] <= gsq[60:30];
    end
  end

  assign ctl_o = gc[NSQUARE];
  assign g_o   = gv[NSQUARE];

endmodule

[sv/gfp_checker.sv]
// Checker: port-level properties of the Gaussian force perturbation, bound to the top level.
module gfp_checker import gfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input gfp_cmd_t    cmd_i,
  input logic        done_o,
  input gfp_res_t    result_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [3:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  // Outside the region the variation is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.in_region |-> result_o.variation == 32'sd0)
    else $error("variation nonzero outside region");

  // Every result comes from a request a fixed latency earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching request");

  // Register port never refuses a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write refused");

  // No result right after reset release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !done_o)
    else $error("result right after reset");

endmodule

bind gaussian_force_perturbation_top gfp_checker u_checker (.*);
